[hw/rtl/wavh_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// WAVE header parser package
// Payload structs, codes, the state encodings and the RIFF/WAVE magic table
// shared by the parser, its arithmetic unit and the top level.
// ============================================================================
package wavh_pkg;

    // One input item: a file byte and the start-of-file mark.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
    } wavh_in_t;

    // One result item.
    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] num_channels;
        logic [31:0] sample_rate;
        logic [5:0]  bit_depth;
        logic [31:0] num_samples;
        logic [31:0] data_offset;
        logic        is_float;
    } wavh_out_t;

    // Configuration registers as seen by the parser.
    typedef struct packed {
        logic [31:0] stream_base;
        logic [31:0] stream_length;
    } wavh_cfg_t;

    // Status codes.
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_BAD_MAGIC   = 3'd1;
    localparam logic [2:0] ST_BAD_FORMAT  = 3'd2;
    localparam logic [2:0] ST_BAD_DEPTH   = 3'd3;
    localparam logic [2:0] ST_BAD_EXT     = 3'd4;
    localparam logic [2:0] ST_BAD_SUBFMT  = 3'd5;
    localparam logic [2:0] ST_OVERRUN     = 3'd6;
    localparam logic [2:0] ST_DATA_NO_FMT = 3'd7;

    // Register indexes of the configuration port.
    localparam logic REG_STREAM_BASE   = 1'b0;
    localparam logic REG_STREAM_LENGTH = 1'b1;

    // Chunk tags, little-endian.
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    // Format codes and fixed sizes.
    localparam logic [15:0] FMT_PCM   = 16'h0001;
    localparam logic [15:0] FMT_FLOAT = 16'h0003;
    localparam logic [15:0] FMT_EXT   = 16'hFFFE;
    localparam logic [15:0] EXT_SIZE  = 16'd22;
    localparam logic [3:0]  HDR_LAST  = 4'd11;

    // Width of the shared adder: wide enough for base + position + size.
    localparam int ALU_W = 35;

    // Parse phase.
    typedef enum logic [4:0] {
        PH_MAGIC = 5'b00001,
        PH_HDR   = 5'b00010,
        PH_FMT   = 5'b00100,
        PH_SKIP  = 5'b01000,
        PH_DONE  = 5'b10000
    } wavh_phase_t;

    // Sequencer state around the shared adder.
    typedef enum logic [6:0] {
        SQ_BYTE = 7'b0000001,
        SQ_OFS  = 7'b0000010,
        SQ_DIV  = 7'b0000100,
        SQ_OVR1 = 7'b0001000,
        SQ_OVR2 = 7'b0010000,
        SQ_OVR3 = 7'b0100000,
        SQ_RES  = 7'b1000000
    } wavh_seq_t;

    // Operation of the shared adder.
    typedef enum logic [1:0] {
        ALU_ADD = 2'b01,
        ALU_SUB = 2'b10
    } wavh_alu_op_t;

    // Expected header byte; the size bytes 4 to 7 are not compared.
    function automatic logic [7:0] magic_byte(input logic [3:0] idx);
        logic [7:0] val;
        case (idx)
            4'd0:    val = 8'h52;
            4'd1:    val = 8'h49;
            4'd2:    val = 8'h46;
            4'd3:    val = 8'h46;
            4'd8:    val = 8'h57;
            4'd9:    val = 8'h41;
            4'd10:   val = 8'h56;
            4'd11:   val = 8'h45;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

[hw/rtl/wavh_alu.sv]
`timescale 1ns / 1ps
// ============================================================================
// WAVE header parser shared adder
// One add/subtract unit that the sequencer uses for the offset sum, the
// overrun check and every step of the sample-count division.
// ============================================================================
module wavh_alu
    import wavh_pkg::*;
(
    input  wavh_alu_op_t       op,
    input  logic [ALU_W-1:0]   opa,
    input  logic [ALU_W-1:0]   opb,
    output logic [ALU_W-1:0]   result
);

    always_comb
    begin
        case (op)
            ALU_ADD: result = opa + opb;
            ALU_SUB: result = opa - opb;
            default: result = opa;
        endcase
    end

endmodule

[hw/rtl/wavh_parser.sv]
`timescale 1ns / 1ps
// ============================================================================
// WAVE header parser core
// Byte-level chunk walker plus the sequencer that drives the shared adder for
// the overrun check, the data offset and the restoring division.
// ============================================================================
module wavh_parser
    import wavh_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  wavh_cfg_t  cfg,
    input  logic       byte_valid,
    output logic       byte_ready,
    input  wavh_in_t   byte_in,
    output logic       res_valid,
    input  logic       res_ready,
    output wavh_out_t  res
);

    wavh_phase_t  phase_reg, phase_next;
    wavh_seq_t    seq_reg, seq_next;
    logic [31:0]  cnt_reg, cnt_next;
    logic [31:0]  tag_reg, tag_next;
    logic [31:0]  size_reg, size_next;
    logic [15:0]  accum_reg, accum_next;
    logic [15:0]  fcode_reg, fcode_next;
    logic [15:0]  chan_reg, chan_next;
    logic [31:0]  rate_reg, rate_next;
    logic [5:0]   depth_reg, depth_next;
    logic         fmt_seen_reg, fmt_seen_next;
    logic [31:0]  pos_reg, pos_next;
    logic [ALU_W-1:0] acc_reg, acc_next;
    logic [31:0]  divq_reg, divq_next;
    logic [1:0]   divr_reg, divr_next;
    logic [4:0]   divn_reg, divn_next;
    logic [2:0]   divd_reg, divd_next;
    wavh_out_t    res_reg, res_next;

    // Parse state as seen by the current byte: a start-of-file byte clears it.
    wavh_phase_t  c_phase;
    logic [31:0]  c_cnt, c_tag, c_size, c_rate, c_pos;
    logic [15:0]  c_accum, c_fcode, c_chan;
    logic [5:0]   c_depth;
    logic         c_fmt_seen;

    logic [7:0]   b;
    logic         in_fire;
    logic [3:0]   mi;
    logic         magic_bad;
    logic [2:0]   hi;
    logic [31:0]  tag_w, size_w;
    logic [5:0]   fi;
    logic [15:0]  accum_w;
    logic [32:0]  skip_diff;
    logic [2:0]   bps;

    wavh_alu_op_t     alu_op;
    logic [ALU_W-1:0] alu_a, alu_b, alu_y;
    logic [2:0]       div_shift;
    logic             div_ok;

    assign b          = byte_in.data_byte;
    assign byte_ready = (seq_reg == SQ_BYTE);
    assign in_fire    = byte_valid && byte_ready;
    assign res_valid  = (seq_reg == SQ_RES);
    assign res        = res_reg;

    always_comb
    begin
        if (byte_in.first_byte)
        begin
            c_phase    = PH_MAGIC;
            c_cnt      = '0;
            c_tag      = '0;
            c_size     = '0;
            c_accum    = '0;
            c_fcode    = '0;
            c_chan     = '0;
            c_rate     = '0;
            c_depth    = '0;
            c_fmt_seen = 1'b0;
            c_pos      = '0;
        end
        else
        begin
            c_phase    = phase_reg;
            c_cnt      = cnt_reg;
            c_tag      = tag_reg;
            c_size     = size_reg;
            c_accum    = accum_reg;
            c_fcode    = fcode_reg;
            c_chan     = chan_reg;
            c_rate     = rate_reg;
            c_depth    = depth_reg;
            c_fmt_seen = fmt_seen_reg;
            c_pos      = pos_reg;
        end
    end

    // Byte decode helpers.
    assign mi        = c_cnt[3:0];
    assign magic_bad = ((mi < 4'd4) || (mi >= 4'd8)) && (b != magic_byte(mi));
    assign hi        = c_cnt[2:0];
    assign fi        = c_cnt[5:0];

    always_comb
    begin
        tag_w  = c_tag;
        size_w = c_size;
        if (!hi[2])
            tag_w[{hi[1:0], 3'b000} +: 8] = b;
        else
            size_w[{hi[1:0], 3'b000} +: 8] = b;
    end

    always_comb
    begin
        accum_w = c_accum;
        if (fi == 6'd0 || fi == 6'd14 || fi == 6'd16 || fi == 6'd24)
            accum_w = {8'h00, b};
        else if (fi == 6'd1 || fi == 6'd15 || fi == 6'd17 || fi == 6'd25)
            accum_w = {b, c_accum[7:0]};
    end

    // Bytes left in the fmt chunk after its fixed fields.
    assign skip_diff = {1'b0, c_size} - ((fi == 6'd15) ? 33'd16 : 33'd40);

    assign bps = (depth_reg[5:3] == 3'd0) ? 3'd1 : depth_reg[5:3];

    // Operand selection for the shared adder.
    assign div_shift = {divr_reg, divq_reg[31]};

    always_comb
    begin
        alu_op = ALU_ADD;
        alu_a  = {{(ALU_W-32){1'b0}}, cfg.stream_base};
        alu_b  = {{(ALU_W-32){1'b0}}, pos_reg};
        case (seq_reg)
            SQ_OVR2:
            begin
                alu_a = acc_reg;
                alu_b = {{(ALU_W-32){1'b0}}, size_reg};
            end
            SQ_OVR3:
            begin
                alu_op = ALU_SUB;
                alu_a  = acc_reg;
                alu_b  = {{(ALU_W-32){1'b0}}, cfg.stream_length};
            end
            SQ_DIV:
            begin
                alu_op = ALU_SUB;
                alu_a  = {{(ALU_W-3){1'b0}}, div_shift};
                alu_b  = {{(ALU_W-3){1'b0}}, divd_reg};
            end
            default:
            begin
                alu_op = ALU_ADD;
            end
        endcase
    end

    wavh_alu u_alu (
        .op     (alu_op),
        .opa    (alu_a),
        .opb    (alu_b),
        .result (alu_y)
    );

    assign div_ok = !alu_y[ALU_W-1];

    always_comb
    begin
        phase_next    = phase_reg;
        seq_next      = seq_reg;
        cnt_next      = cnt_reg;
        tag_next      = tag_reg;
        size_next     = size_reg;
        accum_next    = accum_reg;
        fcode_next    = fcode_reg;
        chan_next     = chan_reg;
        rate_next     = rate_reg;
        depth_next    = depth_reg;
        fmt_seen_next = fmt_seen_reg;
        pos_next      = pos_reg;
        acc_next      = acc_reg;
        divq_next     = divq_reg;
        divr_next     = divr_reg;
        divn_next     = divn_reg;
        divd_next     = divd_reg;
        res_next      = res_reg;

        case (seq_reg)
            SQ_BYTE:
            begin
                if (in_fire)
                begin
                    phase_next    = c_phase;
                    cnt_next      = c_cnt;
                    tag_next      = c_tag;
                    size_next     = c_size;
                    accum_next    = c_accum;
                    fcode_next    = c_fcode;
                    chan_next     = c_chan;
                    rate_next     = c_rate;
                    depth_next    = c_depth;
                    fmt_seen_next = c_fmt_seen;
                    pos_next      = c_pos;
                    if (c_phase != PH_DONE)
                    begin
                        pos_next = c_pos + 32'd1;
                    end
                    case (c_phase)
                        PH_MAGIC:
                        begin
                            if (mi >= HDR_LAST)
                            begin
                                if (c_accum[0] || magic_bad)
                                begin
                                    res_next        = '0;
                                    res_next.status = ST_BAD_MAGIC;
                                    phase_next      = PH_DONE;
                                    seq_next        = SQ_RES;
                                end
                                else
                                begin
                                    phase_next = PH_HDR;
                                    cnt_next   = '0;
                                    tag_next   = '0;
                                    size_next  = '0;
                                end
                            end
                            else
                            begin
                                accum_next[0] = c_accum[0] | magic_bad;
                                cnt_next      = c_cnt + 32'd1;
                            end
                        end
                        PH_SKIP:
                        begin
                            cnt_next = c_cnt - 32'd1;
                            if (c_cnt == 32'd1)
                            begin
                                phase_next = PH_HDR;
                                tag_next   = '0;
                                size_next  = '0;
                            end
                        end
                        PH_HDR:
                        begin
                            tag_next  = tag_w;
                            size_next = size_w;
                            if (hi != 3'd7)
                            begin
                                cnt_next = c_cnt + 32'd1;
                            end
                            else if (tag_w == TAG_FMT)
                            begin
                                phase_next = PH_FMT;
                                cnt_next   = '0;
                                accum_next = '0;
                                chan_next  = '0;
                                rate_next  = '0;
                            end
                            else if (tag_w == TAG_DATA)
                            begin
                                phase_next = PH_DONE;
                                if (!c_fmt_seen)
                                begin
                                    res_next        = '0;
                                    res_next.status = ST_DATA_NO_FMT;
                                    seq_next        = SQ_RES;
                                end
                                else
                                begin
                                    divq_next = size_w;
                                    seq_next  = SQ_OFS;
                                end
                            end
                            else
                            begin
                                seq_next = SQ_OVR1;
                            end
                        end
                        PH_FMT:
                        begin
                            accum_next = accum_w;
                            cnt_next   = c_cnt + 32'd1;
                            if (fi == 6'd2)
                                chan_next[7:0] = b;
                            if (fi == 6'd3)
                                chan_next[15:8] = b;
                            if (fi >= 6'd4 && fi <= 6'd7)
                                rate_next[{fi[1:0], 3'b000} +: 8] = b;
                            if (fi == 6'd1)
                            begin
                                fcode_next = accum_w;
                                if (accum_w != FMT_PCM && accum_w != FMT_FLOAT
                                    && accum_w != FMT_EXT)
                                begin
                                    res_next        = '0;
                                    res_next.status = ST_BAD_FORMAT;
                                    phase_next      = PH_DONE;
                                    seq_next        = SQ_RES;
                                end
                            end
                            else if (fi == 6'd15)
                            begin
                                depth_next = accum_w[5:0];
                                if (accum_w != 16'd8 && accum_w != 16'd16
                                    && accum_w != 16'd24 && accum_w != 16'd32)
                                begin
                                    res_next        = '0;
                                    res_next.status = ST_BAD_DEPTH;
                                    phase_next      = PH_DONE;
                                    seq_next        = SQ_RES;
                                end
                                else if (c_fcode != FMT_EXT)
                                begin
                                    fmt_seen_next = 1'b1;
                                    if (skip_diff[32] || skip_diff[31:0] == 32'd0)
                                    begin
                                        phase_next = PH_HDR;
                                        cnt_next   = '0;
                                        tag_next   = '0;
                                        size_next  = '0;
                                    end
                                    else
                                    begin
                                        phase_next = PH_SKIP;
                                        cnt_next   = skip_diff[31:0];
                                    end
                                end
                            end
                            else if (fi == 6'd17)
                            begin
                                if (accum_w != EXT_SIZE)
                                begin
                                    res_next        = '0;
                                    res_next.status = ST_BAD_EXT;
                                    phase_next      = PH_DONE;
                                    seq_next        = SQ_RES;
                                end
                            end
                            else if (fi == 6'd39)
                            begin
                                if (accum_w != FMT_PCM)
                                begin
                                    res_next        = '0;
                                    res_next.status = ST_BAD_SUBFMT;
                                    phase_next      = PH_DONE;
                                    seq_next        = SQ_RES;
                                end
                                else
                                begin
                                    fcode_next    = FMT_PCM;
                                    fmt_seen_next = 1'b1;
                                    if (skip_diff[32] || skip_diff[31:0] == 32'd0)
                                    begin
                                        phase_next = PH_HDR;
                                        cnt_next   = '0;
                                        tag_next   = '0;
                                        size_next  = '0;
                                    end
                                    else
                                    begin
                                        phase_next = PH_SKIP;
                                        cnt_next   = skip_diff[31:0];
                                    end
                                end
                            end
                        end
                        default:
                        begin
                            phase_next = c_phase;
                        end
                    endcase
                end
            end
            SQ_OFS:
            begin
                res_next.status       = ST_OK;
                res_next.num_channels = chan_reg;
                res_next.sample_rate  = rate_reg;
                res_next.bit_depth    = depth_reg;
                res_next.data_offset  = alu_y[31:0];
                res_next.is_float     = (fcode_reg == FMT_FLOAT);
                divd_next = bps;
                divr_next = '0;
                divn_next = '0;
                seq_next  = SQ_DIV;
            end
            SQ_DIV:
            begin
                // One restoring step: the divisor is at most four, so the
                // remainder never needs more than two bits.
                divr_next = div_ok ? alu_y[1:0] : div_shift[1:0];
                divq_next = {divq_reg[30:0], div_ok};
                divn_next = divn_reg + 5'd1;
                if (divn_reg == 5'd31)
                begin
                    res_next.num_samples = {divq_reg[30:0], div_ok};
                    seq_next             = SQ_RES;
                end
            end
            SQ_OVR1:
            begin
                acc_next = alu_y;
                seq_next = SQ_OVR2;
            end
            SQ_OVR2:
            begin
                acc_next = alu_y;
                seq_next = SQ_OVR3;
            end
            SQ_OVR3:
            begin
                if (!alu_y[ALU_W-1])
                begin
                    res_next        = '0;
                    res_next.status = ST_OVERRUN;
                    phase_next      = PH_DONE;
                    seq_next        = SQ_RES;
                end
                else if (size_reg == 32'd0)
                begin
                    phase_next = PH_HDR;
                    cnt_next   = '0;
                    tag_next   = '0;
                    seq_next   = SQ_BYTE;
                end
                else
                begin
                    phase_next = PH_SKIP;
                    cnt_next   = size_reg;
                    seq_next   = SQ_BYTE;
                end
            end
            SQ_RES:
            begin
                if (res_ready)
                    seq_next = SQ_BYTE;
            end
            default:
            begin
                seq_next = SQ_BYTE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_MAGIC;
            seq_reg      <= SQ_BYTE;
            cnt_reg      <= '0;
            tag_reg      <= '0;
            size_reg     <= '0;
            accum_reg    <= '0;
            fcode_reg    <= '0;
            chan_reg     <= '0;
            rate_reg     <= '0;
            depth_reg    <= '0;
            fmt_seen_reg <= 1'b0;
            pos_reg      <= '0;
            divn_reg     <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            seq_reg      <= seq_next;
            cnt_reg      <= cnt_next;
            tag_reg      <= tag_next;
            size_reg     <= size_next;
            accum_reg    <= accum_next;
            fcode_reg    <= fcode_next;
            chan_reg     <= chan_next;
            rate_reg     <= rate_next;
            depth_reg    <= depth_next;
            fmt_seen_reg <= fmt_seen_next;
            pos_reg      <= pos_next;
            divn_reg     <= divn_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        divq_reg <= divq_next;
        divr_reg <= divr_next;
        divd_reg <= divd_next;
        res_reg  <= res_next;
    end

endmodule

[hw/rtl/wav_header_parser.sv]
`timescale 1ns / 1ps
// ============================================================================
// WAVE header parser
// Walks the RIFF/WAVE header and sub-chunks of a byte stream and reports the
// decoded PCM or float format, or an error code, once per file.
// ============================================================================
// The parser takes one file byte per item and absorbs most bytes without
// holding the input. Longer holds come from the one shared adder in the
// parser core: an unknown chunk header holds the input while SQ_OVR1 to
// SQ_OVR3 compare base + position + size with the stream length, and the
// data chunk header holds it through SQ_OFS (one add for the data offset),
// SQ_DIV (32 restoring division steps for the sample count) and SQ_RES,
// until the result is handed to the output register. A byte that ends the
// parse with an error holds the input in SQ_RES until its result is handed
// off. After a result, bytes are taken one per cycle and ignored until an
// item with first_byte set starts a new file. Results wait in an output
// register, so a stalled result does not stop the input until the next one
// is ready. The stream base and stream length registers sit at byte
// addresses 0 and 4 of the APB port and should be written only between items.
module wav_header_parser
    import wavh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Byte input
    input  logic        in_valid,
    output logic        in_ready,
    input  wavh_in_t    in_data,
    // Result output
    output logic        out_valid,
    input  logic        out_ready,
    output wavh_out_t   out_data,
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    wavh_cfg_t  cfg_reg, cfg_next;
    logic       out_valid_reg, out_valid_next;
    wavh_out_t  out_reg, out_next;
    logic       res_valid, res_ready;
    wavh_out_t  res;
    logic       cfg_wr;

    // Register writes complete in the access phase; reads are combinational.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_STREAM_LENGTH) ? cfg_reg.stream_length
                                                    : cfg_reg.stream_base;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            if (paddr[2] == REG_STREAM_LENGTH)
                cfg_next.stream_length = pwdata;
            else
                cfg_next.stream_base = pwdata;
        end
    end

    wavh_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .byte_valid (in_valid),
        .byte_ready (in_ready),
        .byte_in    (in_data),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // The output register frees up either when empty or as its item leaves.
    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

[hw/rtl/wavh_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// WAVE header parser checker
// Port-level assertions on result items, bound to the top level.
// ============================================================================
module wavh_checker
    import wavh_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       out_valid,
    input  logic       out_ready,
    input  wavh_out_t  out_data
);

    // A stalled result item holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result item changed while stalled");

    // An error result carries nothing but its status.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status != ST_OK) |->
            (out_data.num_channels == 16'd0) && (out_data.sample_rate == 32'd0)
            && (out_data.bit_depth == 6'd0) && (out_data.num_samples == 32'd0)
            && (out_data.data_offset == 32'd0) && !out_data.is_float)
        else $error("error result with nonzero fields");

    // A good result always has one of the accepted depths.
    a_ok_depth: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == ST_OK) |->
            (out_data.bit_depth == 6'd8) || (out_data.bit_depth == 6'd16)
            || (out_data.bit_depth == 6'd24) || (out_data.bit_depth == 6'd32))
        else $error("good result with an unchecked bit depth");

endmodule

bind wav_header_parser wavh_checker u_wavh_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
